// ----- rtl/core/pscgs_pkg.sv -----
// Shared types and constants for the PID speed command block.
// Holds the configuration struct, register indexes and sequencer states.
// No dependencies.
package pscgs_pkg;

    localparam int DATA_W = 32;
    localparam int GAIN_W = 31;
    localparam int GEAR_W = 8;
    localparam int ADDR_W = 3;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 50;

    typedef enum logic [ADDR_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_TIME_STEP      = 3'd3,
        REG_COMMAND_LIMIT  = 3'd4,
        REG_DEADBAND_LIMIT = 3'd5,
        REG_REVERSE_GEAR   = 3'd6,
        REG_FORWARD_GEAR   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] time_step;
        logic [GAIN_W-1:0] command_limit;
        logic [GAIN_W-1:0] deadband_limit;
        logic [GEAR_W-1:0] reverse_gear_code;
        logic [GEAR_W-1:0] forward_gear_code;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_DT,
        ST_INTEG,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_CLAMP,
        ST_DBAND,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/pscgs_cfg.sv -----
// Configuration register file for the PID speed command block.
// Depends on pscgs_pkg for the register indexes and the cfg_t struct.
module pscgs_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pscgs_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [pscgs_pkg::GAIN_W-1:0]  cfg_data,
    output pscgs_pkg::cfg_t               cfg
);

    pscgs_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p            <= 31'd65536;
            cfg_reg.gain_i            <= 31'd0;
            cfg_reg.gain_d            <= 31'd0;
            cfg_reg.time_step         <= 31'd6554;
            cfg_reg.command_limit     <= 31'd1310720;
            cfg_reg.deadband_limit    <= 31'd0;
            cfg_reg.reverse_gear_code <= 8'd0;
            cfg_reg.forward_gear_code <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (pscgs_pkg::reg_index_t'(cfg_addr))
                pscgs_pkg::REG_GAIN_P:         cfg_reg.gain_p         <= cfg_data;
                pscgs_pkg::REG_GAIN_I:         cfg_reg.gain_i         <= cfg_data;
                pscgs_pkg::REG_GAIN_D:         cfg_reg.gain_d         <= cfg_data;
                pscgs_pkg::REG_TIME_STEP:      cfg_reg.time_step      <= cfg_data;
                pscgs_pkg::REG_COMMAND_LIMIT:  cfg_reg.command_limit  <= cfg_data;
                pscgs_pkg::REG_DEADBAND_LIMIT: cfg_reg.deadband_limit <= cfg_data;
                pscgs_pkg::REG_REVERSE_GEAR:
                    cfg_reg.reverse_gear_code <= cfg_data[pscgs_pkg::GEAR_W-1:0];
                pscgs_pkg::REG_FORWARD_GEAR:
                    cfg_reg.forward_gear_code <= cfg_data[pscgs_pkg::GEAR_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/pscgs_mul.sv -----
// Shared registered multiplier: unsigned 31-bit operand times signed 32-bit operand.
// Depends on pscgs_pkg for widths.
module pscgs_mul
(
    input  logic                                clk,
    input  logic [pscgs_pkg::GAIN_W-1:0]        a,
    input  logic signed [pscgs_pkg::DATA_W-1:0] b,
    output logic signed [pscgs_pkg::PROD_W-1:0] product
);

    logic signed [pscgs_pkg::DATA_W-1:0] a_ext;
    logic signed [pscgs_pkg::PROD_W-1:0] product_reg;

    assign a_ext = $signed({1'b0, a});

    always_ff @(posedge clk)
    begin
        product_reg <= a_ext * b;
    end

    assign product = product_reg;

endmodule

// ----- rtl/core/pscgs_div.sv -----
// Iterative restoring divider for the derivative term: sat32(trunc(diff * 2^16 / divisor)).
// One quotient bit per cycle; overflow is detected up front. Depends on pscgs_pkg.
module pscgs_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pscgs_pkg::DATA_W:0]          diff,
    input  logic [pscgs_pkg::GAIN_W-1:0]        divisor,
    output logic                                done,
    output logic signed [pscgs_pkg::DATA_W-1:0] quotient
);

    logic [32:0] mag;
    logic [48:0] dividend;
    logic [45:0] ovf_limit;
    logic        ovf;
    logic [31:0] trial;
    logic [31:0] trial_sub;
    logic        fits;
    logic [31:0] q_ext;

    logic [30:0] rem_reg;
    logic [30:0] bits_reg;
    logic [30:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic        ovf_reg;

    assign mag       = diff[32] ? 33'(-diff) : diff;
    assign dividend  = {mag, 16'd0};
    assign ovf_limit = {divisor, 15'd0};
    assign ovf       = {13'd0, mag} >= ovf_limit;

    assign trial     = {rem_reg, bits_reg[30]};
    assign trial_sub = trial - {1'b0, divisor};
    assign fits      = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'd31;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= diff[32];
            ovf_reg  <= ovf;
            rem_reg  <= {13'd0, dividend[48:31]};
            bits_reg <= dividend[30:0];
            q_reg    <= 31'd0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_sub[30:0] : trial[30:0];
            bits_reg <= {bits_reg[29:0], 1'b0};
            q_reg    <= {q_reg[29:0], fits};
        end
    end

    assign q_ext = {1'b0, q_reg};

    always_comb
    begin
        if (ovf_reg)
        begin
            quotient = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            quotient = neg_reg ? $signed(32'(-q_ext)) : $signed(q_ext);
        end
    end

    assign done = done_reg;

endmodule

// ----- rtl/core/pid_speed_command_with_gear_select.sv -----
// Top level of the incremental PID speed command block with gear select.
// Depends on pscgs_pkg, pscgs_cfg, pscgs_mul and pscgs_div.
//
// Usage: one signed Q16.16 target speed enters per transfer on the s_ channel.
// The block forms the error against its kept command, updates the integral,
// the derivative and the command, and delivers one transfer on the m_ channel
// holding the new command and the gear code.
// m_tvalid rises once the sequencer has passed its error, integral, divider,
// product, clamp and deadband states; a saturated derivative skips the 31
// divider steps. Those steps dominate; one shared 31x32 multiplier handles
// the four products in turn. s_tready is high only while the sequencer is
// idle, so a new item is taken only once the previous one has left it. The
// output sits in a register: a new item is taken while a result still waits,
// and the sequencer holds its finished result until the output register is
// free when the receiver stalls. Reset clears the command, the integral and
// the previous error, loads the register defaults and empties the output
// register. The user must write configuration through cfg_we, cfg_addr and
// cfg_data only while idle; the block itself leaves this unchecked.
module pid_speed_command_with_gear_select
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // [31:0] target_speed
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,   // [31:0] speed_command, [39:32] gear_select
    input  logic                                cfg_we,
    input  logic [pscgs_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [pscgs_pkg::GAIN_W-1:0]        cfg_data
);

    pscgs_pkg::cfg_t   cfg;
    pscgs_pkg::state_t state_reg;
    pscgs_pkg::state_t state_next;

    logic [31:0] target_reg;
    logic [31:0] err_reg;
    logic [31:0] integ_reg;
    logic [31:0] last_err_reg;
    logic [31:0] de_reg;
    logic [31:0] cmd_reg;
    logic [pscgs_pkg::ACC_W-1:0] acc_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic [30:0] dt;
    logic [30:0] mul_a;
    logic [31:0] mul_b;
    logic signed [63:0] product;
    logic [47:0] prod_q;
    logic [pscgs_pkg::ACC_W-1:0] prod_ext;

    logic [32:0] err_diff;
    logic [31:0] err_sat;
    logic [48:0] integ_sum;
    logic [31:0] integ_sat;
    logic [32:0] de_diff;
    logic        div_start;
    logic        div_done;
    logic signed [31:0] div_q;

    logic [50:0] cmd_sum;
    logic [50:0] lim_pos;
    logic [50:0] lim_neg;
    logic [31:0] cmd_clamped;
    logic [31:0] cmd_mag;
    logic        out_free;

    pscgs_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    pscgs_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       ($signed(mul_b)),
        .product (product)
    );

    pscgs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .diff     (de_diff),
        .divisor  (dt),
        .done     (div_done),
        .quotient (div_q)
    );

    assign dt = (cfg.time_step == 31'd0) ? 31'd1 : cfg.time_step;

    assign err_diff = {target_reg[31], target_reg} - {cmd_reg[31], cmd_reg};
    assign err_sat  = (err_diff[32] != err_diff[31])
                    ? (err_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                    : err_diff[31:0];

    assign prod_q    = product[63:16];
    assign prod_ext  = {{2{prod_q[47]}}, prod_q};
    assign integ_sum = {{17{integ_reg[31]}}, integ_reg} + {prod_q[47], prod_q};
    assign integ_sat = ((&integ_sum[48:31]) || !(|integ_sum[48:31]))
                     ? integ_sum[31:0]
                     : (integ_sum[48] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign de_diff   = {err_reg[31], err_reg} - {last_err_reg[31], last_err_reg};
    assign div_start = (state_reg == pscgs_pkg::ST_DIV_START);

    assign cmd_sum = {{19{cmd_reg[31]}}, cmd_reg} + {acc_reg[49], acc_reg};
    assign lim_pos = {20'd0, cfg.command_limit};
    assign lim_neg = 51'd0 - lim_pos;

    always_comb
    begin
        if ($signed(cmd_sum) > $signed(lim_pos))
        begin
            cmd_clamped = lim_pos[31:0];
        end
        else if ($signed(cmd_sum) < $signed(lim_neg))
        begin
            cmd_clamped = lim_neg[31:0];
        end
        else
        begin
            cmd_clamped = cmd_sum[31:0];
        end
    end

    assign cmd_mag  = cmd_reg[31] ? 32'(-cmd_reg) : cmd_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        case (state_reg)
            pscgs_pkg::ST_MUL_DT:
            begin
                mul_a = dt;
                mul_b = err_reg;
            end
            pscgs_pkg::ST_MUL_I:
            begin
                mul_a = cfg.gain_i;
                mul_b = integ_reg;
            end
            pscgs_pkg::ST_MUL_D:
            begin
                mul_a = cfg.gain_d;
                mul_b = de_reg;
            end
            default:
            begin
                mul_a = cfg.gain_p;
                mul_b = err_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pscgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pscgs_pkg::ST_IDLE:      if (s_tvalid) state_next = pscgs_pkg::ST_ERR;
            pscgs_pkg::ST_ERR:       state_next = pscgs_pkg::ST_MUL_DT;
            pscgs_pkg::ST_MUL_DT:    state_next = pscgs_pkg::ST_INTEG;
            pscgs_pkg::ST_INTEG:     state_next = pscgs_pkg::ST_DIV_START;
            pscgs_pkg::ST_DIV_START: state_next = pscgs_pkg::ST_DIV_WAIT;
            pscgs_pkg::ST_DIV_WAIT:  if (div_done) state_next = pscgs_pkg::ST_MUL_P;
            pscgs_pkg::ST_MUL_P:     state_next = pscgs_pkg::ST_MUL_I;
            pscgs_pkg::ST_MUL_I:     state_next = pscgs_pkg::ST_MUL_D;
            pscgs_pkg::ST_MUL_D:     state_next = pscgs_pkg::ST_ACC_D;
            pscgs_pkg::ST_ACC_D:     state_next = pscgs_pkg::ST_CLAMP;
            pscgs_pkg::ST_CLAMP:     state_next = pscgs_pkg::ST_DBAND;
            pscgs_pkg::ST_DBAND:     state_next = pscgs_pkg::ST_DONE;
            pscgs_pkg::ST_DONE:      if (out_free) state_next = pscgs_pkg::ST_IDLE;
            default:                 state_next = pscgs_pkg::ST_IDLE;
        endcase
    end

    // Controller state: command, integral, previous error and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= 32'd0;
            integ_reg     <= 32'd0;
            last_err_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == pscgs_pkg::ST_INTEG)
            begin
                integ_reg <= integ_sat;
            end
            if (state_reg == pscgs_pkg::ST_ACC_D)
            begin
                last_err_reg <= err_reg;
            end
            if (state_reg == pscgs_pkg::ST_CLAMP)
            begin
                cmd_reg <= cmd_clamped;
            end
            if ((state_reg == pscgs_pkg::ST_DBAND) && (cmd_mag <= {1'b0, cfg.deadband_limit}))
            begin
                cmd_reg <= 32'd0;
            end
            if ((state_reg == pscgs_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == pscgs_pkg::ST_IDLE) && s_tvalid)
        begin
            target_reg <= s_tdata;
        end
        if (state_reg == pscgs_pkg::ST_ERR)
        begin
            err_reg <= err_sat;
        end
        if ((state_reg == pscgs_pkg::ST_DIV_WAIT) && div_done)
        begin
            de_reg <= div_q;
        end
        if (state_reg == pscgs_pkg::ST_MUL_I)
        begin
            acc_reg <= prod_ext;
        end
        if ((state_reg == pscgs_pkg::ST_MUL_D) || (state_reg == pscgs_pkg::ST_ACC_D))
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        if ((state_reg == pscgs_pkg::ST_DONE) && out_free)
        begin
            out_data_reg <= {(cmd_reg[31] ? cfg.reverse_gear_code : cfg.forward_gear_code),
                             cmd_reg};
        end
    end

    assign s_tready = (state_reg == pscgs_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
